### hw/rtl/first_fit_block_allocator_core_assert.svh
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FFBA_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FFBA_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int STATUS_W = 3;
  localparam int BSIZE_W  = 16;
  localparam int GRANT_W  = 16;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic alloc;  // allocate committing this cycle
    logic append; // free committing this cycle, list not full
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/ffba_cell.sv
`default_nettype none

module ffba_cell #(
  parameter int IDX       = 0,
  parameter int CNT_W     = 5,
  parameter int SIZE_BITS = ffba_pkg::SIZE_BITS_DEF
) (
  input  wire                          clk,
  input  wire ffba_pkg::cell_ctl_t     ctl,
  input  wire logic [CNT_W-1:0]        count,
  input  wire logic [SIZE_BITS-1:0]    req_size,
  input  wire logic                    found_in,
  input  wire logic [SIZE_BITS-1:0]    grant_in,
  input  wire logic [SIZE_BITS-1:0]    next_value,
  output logic                         found_out,
  output logic [SIZE_BITS-1:0]         grant_out,
  output logic [SIZE_BITS-1:0]         value
);

  logic in_use;
  logic hit;

  assign in_use    = count > CNT_W'(IDX);
  assign hit       = in_use && (value >= req_size);
  assign found_out = found_in | hit;
  assign grant_out = (hit && !found_in) ? value : grant_in;

  // on allocate every cell at or past the taken one pulls from its neighbor
  always_ff @(posedge clk) begin
    if (ctl.alloc && found_out) begin
      value <= next_value;
    end else if (ctl.append && (count == CNT_W'(IDX))) begin
      value <= req_size;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/first_fit_block_allocator_core.sv
`default_nettype none
// first-fit free block allocator
// input channel: in_valid / in_stall with command and block_size; a word is taken
//   at a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with status, granted_size and free_count;
//   exactly one result word per input word, in order
// config channel: cfg_valid / cfg_ready with capacity; cfg_ready is always high,
//   write only while no request is in flight
// a taken request is first held in the request registers; its result is then written
//   to the output register once that register is free or draining
// throughput: one request per cycle while the output is not stalled; the list is
//   a row of cells with a found/grant chain, so a request finishes in one pass
// when the receiver stalls, the result waits in the output register and one more
//   request may be taken and held; then in_stall rises until the output drains
// reset: list emptied (internal count 0), capacity back to 16, no results pending;
//   no clearing pass is needed
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // request channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           command,
  input  wire logic [ffba_pkg::BSIZE_W-1:0]   block_size,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [ffba_pkg::STATUS_W-1:0]       status,
  output logic [ffba_pkg::GRANT_W-1:0]        granted_size,
  output logic [ffba_pkg::COUNT_W-1:0]        free_count,
  // config channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ffba_pkg::CAP_W-1:0]     capacity
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  // held request
  logic                 busy;
  logic                 op_cmd;
  logic [SIZE_BITS-1:0] op_size;

  // list state
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [ffba_pkg::CAP_W-1:0] cap_reg;

  // cell chain
  logic [MAX_BLOCKS:0]        found;
  logic [SIZE_BITS-1:0]       grant [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0]       cell_value [MAX_BLOCKS];
  ffba_pkg::cell_ctl_t        ctl;

  logic                commit;
  logic                accept;
  logic                full;
  ffba_pkg::status_t   res_status;
  logic [SIZE_BITS-1:0] res_grant;

  // the held request completes when the output register is free or draining
  assign commit    = busy && (!out_valid || !out_stall);
  assign in_stall  = busy && !commit;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // capacity above the row length saturates to the row length
  assign full = (32'(count) >= 32'(cap_reg)) || (32'(count) >= MAX_BLOCKS);

  assign found[0] = 1'b0;
  assign grant[0] = '0;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    logic [SIZE_BITS-1:0] nbr;
    // last cell has no neighbor; what it pulls is past the list end
    if (i == MAX_BLOCKS - 1) begin : g_last
      assign nbr = cell_value[i];
    end else begin : g_mid
      assign nbr = cell_value[i+1];
    end
    ffba_cell #(
      .IDX       (i),
      .CNT_W     (CNT_W),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .req_size   (op_size),
      .found_in   (found[i]),
      .grant_in   (grant[i]),
      .next_value (nbr),
      .found_out  (found[i+1]),
      .grant_out  (grant[i+1]),
      .value      (cell_value[i])
    );
  end

  // result and list update for the held request
  always_comb begin
    res_status = ffba_pkg::ST_NO_FIT;
    res_grant  = '0;
    count_next = count;
    ctl        = '0;
    if (op_cmd == ffba_pkg::CMD_ALLOC) begin
      if (count == '0) begin
        res_status = ffba_pkg::ST_EMPTY;
      end else if (found[MAX_BLOCKS]) begin
        res_status = ffba_pkg::ST_ALLOCATED;
        res_grant  = grant[MAX_BLOCKS];
        count_next = count - CNT_W'(1);
        ctl.alloc  = commit;
      end
    end else begin
      if (full) begin
        res_status = ffba_pkg::ST_FULL;
      end else begin
        res_status = ffba_pkg::ST_FREED;
        count_next = count + CNT_W'(1);
        ctl.append = commit;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
      cap_reg   <= ffba_pkg::CAP_RESET;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg <= capacity;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd  <= command;
      op_size <= SIZE_BITS'(block_size);
    end
    if (commit) begin
      status       <= res_status;
      granted_size <= ffba_pkg::GRANT_W'(res_grant);
      free_count   <= ffba_pkg::COUNT_W'(count_next);
    end
  end

`include "first_fit_block_allocator_core_assert.svh"

  `FFBA_ASSERT_NOW(a_count_bound, 1'b1, 32'(count) <= MAX_BLOCKS, "free count past row length")

  `FFBA_ASSERT_NOW(a_grant_zero, out_valid && (status != ffba_pkg::ST_ALLOCATED), granted_size == '0, "grant on non-allocate")

  `FFBA_ASSERT_NEXT(a_append_count, commit && ctl.append, count == $past(count) + CNT_W'(1), "append lost count")

  `FFBA_ASSERT_NEXT(a_commit_valid, commit, out_valid, "committed result not shown")

endmodule

`default_nettype wire
